// ===== rtl/core/h2r_pkg.sv =====
// Shared widths, constants, codes and the queue entry type for the HSV to RGB converter.
package h2r_pkg;

	localparam int HUE_W    = 9;
	localparam int PCT_W    = 7;
	localparam int CHAN_W   = 8;
	localparam int SECTOR_W = 3;
	localparam int FRAC_W   = 6;   // hue offset inside a sector, 0..59
	localparam int NUM_W    = 13;  // channel numerator, 0..6000

	localparam int SECTOR_DEG = 60;
	localparam int FULL_TURN  = 360;
	localparam int PCT_MAX    = 100;
	localparam int NUM_ONE    = PCT_MAX * SECTOR_DEG;

	// floor(255 * v * num / 600000) == floor(floor(17 * v * num / 64) / 625)
	localparam int PROD_W   = 20;  // v * num <= 600000
	localparam int SCALED_W = 24;  // 17 * v * num
	localparam int DROP_SH  = 6;
	localparam int Y_W      = SCALED_W - DROP_SH;
	// ceil(2^28 / 625); exact division for every quotient input below 2^18
	localparam int RECIP    = 429497;
	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = 19;
	localparam int MUL_W    = Y_W + RECIP_W;

	localparam int H2R_QUEUE_DEPTH = 2;

	typedef logic [SECTOR_W-1:0] sector_t;

	localparam sector_t SEC_R_TO_Y = 3'd0;
	localparam sector_t SEC_Y_TO_G = 3'd1;
	localparam sector_t SEC_G_TO_C = 3'd2;
	localparam sector_t SEC_C_TO_B = 3'd3;
	localparam sector_t SEC_B_TO_M = 3'd4;
	localparam sector_t SEC_M_TO_R = 3'd5;

	// lanes of the back end, one per candidate channel value
	localparam int LANE_V  = 0;
	localparam int LANE_P  = 1;
	localparam int LANE_Q  = 2;
	localparam int LANE_T  = 3;
	localparam int N_LANES = 4;

	typedef struct packed {
		logic [PCT_W-1:0] v;
		sector_t          sector;
		logic             grey;
		logic [NUM_W-1:0] num_p;
		logic [NUM_W-1:0] num_q;
		logic [NUM_W-1:0] num_t;
	} h2r_job_t;

endpackage

// ===== rtl/core/h2r_if.sv =====
// Stream interfaces for HSV input pixels and RGB result pixels.
interface h2r_hsv_if;
	import h2r_pkg::*;

	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation;
	logic [PCT_W-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface h2r_rgb_if;
	import h2r_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/core/h2r_front.sv =====
// Front end: clamps and wraps the pixel, finds the hue sector and the channel numerators.
module h2r_front (
	h2r_hsv_if.sink           hsv,
	output logic              push_valid,
	input  logic              push_ready,
	output h2r_pkg::h2r_job_t push_job
);
	import h2r_pkg::*;

	logic [HUE_W-1:0]  hue_w;
	logic [HUE_W-1:0]  base;
	logic [FRAC_W-1:0] m;
	logic [PCT_W-1:0]  s_cl;
	logic [PCT_W-1:0]  v_cl;
	sector_t           sector;
	logic [NUM_W-1:0]  sm;
	logic [NUM_W-1:0]  s_rest;

	always_comb begin
		if (hsv.hue >= HUE_W'(FULL_TURN)) begin
			hue_w = hsv.hue - HUE_W'(FULL_TURN);
		end else begin
			hue_w = hsv.hue;
		end

		priority if (hue_w >= HUE_W'(5 * SECTOR_DEG)) begin
			sector = SEC_M_TO_R;
			base   = HUE_W'(5 * SECTOR_DEG);
		end else if (hue_w >= HUE_W'(4 * SECTOR_DEG)) begin
			sector = SEC_B_TO_M;
			base   = HUE_W'(4 * SECTOR_DEG);
		end else if (hue_w >= HUE_W'(3 * SECTOR_DEG)) begin
			sector = SEC_C_TO_B;
			base   = HUE_W'(3 * SECTOR_DEG);
		end else if (hue_w >= HUE_W'(2 * SECTOR_DEG)) begin
			sector = SEC_G_TO_C;
			base   = HUE_W'(2 * SECTOR_DEG);
		end else if (hue_w >= HUE_W'(SECTOR_DEG)) begin
			sector = SEC_Y_TO_G;
			base   = HUE_W'(SECTOR_DEG);
		end else begin
			sector = SEC_R_TO_Y;
			base   = '0;
		end
		m = FRAC_W'(hue_w - base);

		s_cl = (hsv.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.saturation;
		v_cl = (hsv.brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.brightness;

		sm     = NUM_W'(s_cl) * NUM_W'(m);
		s_rest = NUM_W'(s_cl) * NUM_W'(FRAC_W'(SECTOR_DEG) - m);

		push_job.v      = v_cl;
		push_job.sector = sector;
		push_job.grey   = (s_cl == '0);
		push_job.num_p  = NUM_W'(PCT_W'(PCT_MAX) - s_cl) * NUM_W'(SECTOR_DEG);
		push_job.num_q  = NUM_W'(NUM_ONE) - sm;
		push_job.num_t  = NUM_W'(NUM_ONE) - s_rest;
	end

	assign push_valid = hsv.valid;
	assign hsv.ready  = push_ready;

endmodule

// ===== rtl/core/h2r_queue.sv =====
// Short FIFO of classified pixels between the front end and the back end.
module h2r_queue #(
	parameter int DEPTH = h2r_pkg::H2R_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  h2r_pkg::h2r_job_t push_job,
	output logic              pop_valid,
	input  logic              pop_ready,
	output h2r_pkg::h2r_job_t pop_job
);
	import h2r_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	h2r_job_t           slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a pop");
`endif

endmodule

// ===== rtl/core/h2r_back.sv =====
// Back end: four-lane scaling pipeline and sector-based channel selection.
module h2r_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  h2r_pkg::h2r_job_t pop_job,
	h2r_rgb_if.source         rgb
);
	import h2r_pkg::*;

	logic                adv;
	logic [NUM_W-1:0]    num    [N_LANES];
	logic [SCALED_W-1:0] scaled [N_LANES];
	logic [CHAN_W-1:0]   chan   [N_LANES];

	logic                vld_s1, vld_s2, vld_s3, vld_q;
	sector_t             sector_s1, sector_s2, sector_s3;
	logic                grey_s1, grey_s2, grey_s3;
	logic [PROD_W-1:0]   prod_s1 [N_LANES];
	logic [Y_W-1:0]      y_s2    [N_LANES];
	logic [MUL_W-1:0]    mul_s3  [N_LANES];
	logic [CHAN_W-1:0]   red_q, green_q, blue_q;

	// whole pipeline moves when the output register is empty or being drained
	assign adv       = !vld_q || rgb.ready;
	assign pop_ready = adv;

	always_comb begin
		num[LANE_V] = NUM_W'(NUM_ONE);
		num[LANE_P] = pop_job.num_p;
		num[LANE_Q] = pop_job.num_q;
		num[LANE_T] = pop_job.num_t;
		for (int k = 0; k < N_LANES; k++) begin
			scaled[k] = (SCALED_W'(prod_s1[k]) << 4) + SCALED_W'(prod_s1[k]);
			chan[k]   = mul_s3[k][RECIP_SH +: CHAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= pop_job.sector;
			grey_s1   <= pop_job.grey;
			sector_s2 <= sector_s1;
			grey_s2   <= grey_s1;
			sector_s3 <= sector_s2;
			grey_s3   <= grey_s2;
			for (int k = 0; k < N_LANES; k++) begin
				prod_s1[k] <= PROD_W'(pop_job.v) * PROD_W'(num[k]);
				y_s2[k]    <= scaled[k][SCALED_W-1:DROP_SH];
				mul_s3[k]  <= MUL_W'(y_s2[k]) * MUL_W'(RECIP);
			end
			if (grey_s3) begin
				red_q   <= chan[LANE_V];
				green_q <= chan[LANE_V];
				blue_q  <= chan[LANE_V];
			end else begin
				unique case (sector_s3)
					SEC_R_TO_Y: begin
						red_q   <= chan[LANE_V];
						green_q <= chan[LANE_T];
						blue_q  <= chan[LANE_P];
					end
					SEC_Y_TO_G: begin
						red_q   <= chan[LANE_Q];
						green_q <= chan[LANE_V];
						blue_q  <= chan[LANE_P];
					end
					SEC_G_TO_C: begin
						red_q   <= chan[LANE_P];
						green_q <= chan[LANE_V];
						blue_q  <= chan[LANE_T];
					end
					SEC_C_TO_B: begin
						red_q   <= chan[LANE_P];
						green_q <= chan[LANE_Q];
						blue_q  <= chan[LANE_V];
					end
					SEC_B_TO_M: begin
						red_q   <= chan[LANE_T];
						green_q <= chan[LANE_P];
						blue_q  <= chan[LANE_V];
					end
					default: begin
						red_q   <= chan[LANE_V];
						green_q <= chan[LANE_P];
						blue_q  <= chan[LANE_Q];
					end
				endcase
			end
		end
	end

	assign rgb.valid = vld_q;
	assign rgb.red   = red_q;
	assign rgb.green = green_q;
	assign rgb.blue  = blue_q;

`ifndef SYNTHESIS
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s3 |=> vld_q)
		else $error("pixel lost between last stage and output register");

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s3 && grey_s3 |=> (rgb.red == rgb.green) && (rgb.green == rgb.blue))
		else $error("grey pixel left with unequal channels");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> sector_s3 <= SEC_M_TO_R)
		else $error("hue sector out of range in pipeline");
`endif

endmodule

// ===== rtl/core/hsv_to_rgb_pixel.sv =====
// Top level of the HSV to RGB pixel converter.
// Converts one pixel per clock from hue (degrees, 360..511 wrap by 360) and saturation and
// brightness (percent, clamped at 100) to 8-bit red, green and blue, each the exact floor of
// 255 times the channel fraction. Sustained rate is one pixel every cycle while the output
// is not stalled. Each pixel passes through the queue and then the four-stage scaling
// pipeline in the back end (multiply by brightness, scale by 17/64, reciprocal multiply for
// the division by 625, sector select into the output register), which advances as a whole
// whenever its output register is empty or being taken. A short queue between the front end
// and the back end keeps input transfers going while a finished result waits, until it is
// full. No state is kept between pixels and no configuration exists.
module hsv_to_rgb_pixel #(
	parameter int QUEUE_DEPTH = h2r_pkg::H2R_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	h2r_hsv_if.sink   hsv,
	h2r_rgb_if.source rgb
);
	import h2r_pkg::*;

	logic     push_valid;
	logic     push_ready;
	h2r_job_t push_job;
	logic     pop_valid;
	logic     pop_ready;
	h2r_job_t pop_job;

	h2r_front u_front (
		.hsv        (hsv),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	h2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	h2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.rgb       (rgb)
	);

endmodule
